/* design/owts_pkg.sv */
// shared types and constants for the one-wire temperature read sequencer
package owts_pkg;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_RST_RSP = 2'd1,
    OP_BYTE    = 2'd2,
    OP_DONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_RESET  = 3'd0,
    KIND_WRITE  = 3'd1,
    KIND_WAIT   = 3'd2,
    KIND_READ   = 3'd3,
    KIND_REPORT = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_FOUND      = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_READ_ERROR = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_RESET1  = 4'd1,
    PH_SKIP1   = 4'd2,
    PH_CONVERT = 4'd3,
    PH_WAITING = 4'd4,
    PH_RESET2  = 4'd5,
    PH_SKIP2   = 4'd6,
    PH_READCMD = 4'd7,
    PH_READING = 4'd8
  } phase_t;

  localparam logic [7:0]  CMD_SKIP_ROM   = 8'hCC;
  localparam logic [7:0]  CMD_CONVERT    = 8'h44;
  localparam logic [7:0]  CMD_READ_PAD   = 8'hBE;
  localparam logic [7:0]  CRC_POLY       = 8'h8C;
  localparam logic [15:0] WAIT_MS_RESET  = 16'd750;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         pin;
    logic [7:0]         wdata;
    logic [15:0]        delay_ms;
    status_t            status;
    logic signed [15:0] temp;
  } res_t;

endpackage

/* design/owts_crc8.sv */
// one byte step of the reflected crc-8 over polynomial 0x8c
module owts_crc8 (
  input  logic [7:0] crc_in,
  input  logic [7:0] data,
  output logic [7:0] crc_out
);

  always_comb begin
    logic [7:0] c;
    logic [7:0] d;
    c = crc_in;
    d = data;
    for (int b = 0; b < 8; b++) begin
      if ((c[0] ^ d[0]) == 1'b1) begin
        c = (c >> 1) ^ owts_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    crc_out = c;
  end

endmodule

/* design/owts_seq.sv */
// read sequence state machine: phase, byte count, crc and temperature bytes
module owts_seq #(
  parameter int SCRATCH_BYTES = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               go,
  input  owts_pkg::op_t      op,
  input  logic               presence,
  input  logic [7:0]         read_data,
  input  logic [7:0]         pin,
  output logic               res_vld,
  output owts_pkg::res_t     res
);

  localparam int IDX_W = $clog2(SCRATCH_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCRATCH_BYTES - 1);

  owts_pkg::phase_t phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [7:0]       t_lo_r, t_lo_nxt;
  logic [7:0]       t_hi_r, t_hi_nxt;
  logic [7:0]       pin_r, pin_nxt;
  logic [15:0]      wait_ms_r;
  logic [7:0]       crc_step;

  owts_crc8 u_crc (
    .crc_in  (crc_r),
    .data    (read_data),
    .crc_out (crc_step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= owts_pkg::PH_IDLE;
      idx_r     <= '0;
      crc_r     <= '0;
      pin_r     <= '0;
      wait_ms_r <= owts_pkg::WAIT_MS_RESET;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      crc_r   <= crc_nxt;
      pin_r   <= pin_nxt;
      if (cfg_we) begin
        wait_ms_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    t_lo_r <= t_lo_nxt;
    t_hi_r <= t_hi_nxt;
  end

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    t_lo_nxt  = t_lo_r;
    t_hi_nxt  = t_hi_r;
    pin_nxt   = pin_r;
    res_vld   = 1'b0;
    res       = '0;
    if (go) begin
      case (phase_r)
        owts_pkg::PH_IDLE: begin
          if (op == owts_pkg::OP_START) begin
            pin_nxt   = pin;
            phase_nxt = owts_pkg::PH_RESET1;
            res_vld   = 1'b1;
            res.kind  = owts_pkg::KIND_RESET;
          end
        end
        owts_pkg::PH_RESET1, owts_pkg::PH_RESET2: begin
          if (op == owts_pkg::OP_RST_RSP) begin
            res_vld = 1'b1;
            if (!presence) begin
              phase_nxt  = owts_pkg::PH_IDLE;
              res.kind   = owts_pkg::KIND_REPORT;
              res.status = (phase_r == owts_pkg::PH_RESET1) ?
                           owts_pkg::ST_NOT_FOUND : owts_pkg::ST_READ_ERROR;
            end else begin
              phase_nxt = (phase_r == owts_pkg::PH_RESET1) ?
                          owts_pkg::PH_SKIP1 : owts_pkg::PH_SKIP2;
              res.kind  = owts_pkg::KIND_WRITE;
              res.wdata = owts_pkg::CMD_SKIP_ROM;
            end
          end
        end
        owts_pkg::PH_SKIP1: begin
          if (op == owts_pkg::OP_DONE) begin
            phase_nxt = owts_pkg::PH_CONVERT;
            res_vld   = 1'b1;
            res.kind  = owts_pkg::KIND_WRITE;
            res.wdata = owts_pkg::CMD_CONVERT;
          end
        end
        owts_pkg::PH_CONVERT: begin
          if (op == owts_pkg::OP_DONE) begin
            phase_nxt    = owts_pkg::PH_WAITING;
            res_vld      = 1'b1;
            res.kind     = owts_pkg::KIND_WAIT;
            res.delay_ms = wait_ms_r;
          end
        end
        owts_pkg::PH_WAITING: begin
          if (op == owts_pkg::OP_DONE) begin
            phase_nxt = owts_pkg::PH_RESET2;
            res_vld   = 1'b1;
            res.kind  = owts_pkg::KIND_RESET;
          end
        end
        owts_pkg::PH_SKIP2: begin
          if (op == owts_pkg::OP_DONE) begin
            phase_nxt = owts_pkg::PH_READCMD;
            res_vld   = 1'b1;
            res.kind  = owts_pkg::KIND_WRITE;
            res.wdata = owts_pkg::CMD_READ_PAD;
          end
        end
        owts_pkg::PH_READCMD: begin
          if (op == owts_pkg::OP_DONE) begin
            idx_nxt   = '0;
            crc_nxt   = '0;
            phase_nxt = owts_pkg::PH_READING;
            res_vld   = 1'b1;
            res.kind  = owts_pkg::KIND_READ;
          end
        end
        owts_pkg::PH_READING: begin
          if (op == owts_pkg::OP_BYTE) begin
            res_vld = 1'b1;
            if (idx_r != LAST_IDX) begin
              if (idx_r == IDX_W'(0)) begin
                t_lo_nxt = read_data;
              end
              if (idx_r == IDX_W'(1)) begin
                t_hi_nxt = read_data;
              end
              crc_nxt  = crc_step;
              idx_nxt  = idx_r + IDX_W'(1);
              res.kind = owts_pkg::KIND_READ;
            end else begin
              // last byte carries the crc of all earlier ones
              phase_nxt = owts_pkg::PH_IDLE;
              idx_nxt   = '0;
              res.kind  = owts_pkg::KIND_REPORT;
              if (crc_r != read_data) begin
                res.status = owts_pkg::ST_READ_ERROR;
              end else begin
                res.status = owts_pkg::ST_FOUND;
                res.temp   = {t_hi_r, t_lo_r};
              end
            end
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
    res.pin = pin_nxt;
  end

  a_report_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.kind == owts_pkg::KIND_REPORT) |=> phase_r == owts_pkg::PH_IDLE)
    else $error("report did not return the sequence to idle");

  a_idx_only_reading: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != owts_pkg::PH_READING) |-> idx_r == '0)
    else $error("byte index left nonzero outside the read phase");

  a_found_needs_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.kind == owts_pkg::KIND_REPORT && res.status == owts_pkg::ST_FOUND)
      |-> crc_r == read_data)
    else $error("found report without matching crc");

endmodule

/* design/owts_out_buf.sv */
// result register with a skid stage so the input side keeps flowing
module owts_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  owts_pkg::res_t push_data,
  output logic           full,
  output logic           out_vld,
  output owts_pkg::res_t out_data,
  input  logic           out_stall
);

  logic           out_vld_r, out_vld_nxt;
  logic           skd_vld_r, skd_vld_nxt;
  owts_pkg::res_t out_r, out_nxt;
  owts_pkg::res_t skd_r, skd_nxt;
  logic           take;

  assign take     = out_vld_r && !out_stall;
  assign full     = skd_vld_r;
  assign out_vld  = out_vld_r;
  assign out_data = out_r;

  always_comb begin
    out_vld_nxt = out_vld_r;
    skd_vld_nxt = skd_vld_r;
    out_nxt     = out_r;
    skd_nxt     = skd_r;
    if (take) begin
      if (skd_vld_r) begin
        out_nxt     = skd_r;
        skd_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = push;
        out_nxt     = push_data;
      end
    end else if (!out_vld_r) begin
      out_vld_nxt = push;
      out_nxt     = push_data;
    end else if (push) begin
      skd_vld_nxt = 1'b1;
      skd_nxt     = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      skd_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      skd_vld_r <= skd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    skd_r <= skd_nxt;
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skd_vld_r |-> out_vld_r)
    else $error("skid holds a result while the output register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skd_vld_r)
    else $error("result pushed into a full buffer");

endmodule

/* design/onewire_temp_sensor_read_sequencer_top.sv */
// One-wire temperature sensor read sequencer. A start request begins a read; each bus
// response request then yields the next bus command (reset, skip-rom, convert, wait,
// reset, skip-rom, read scratchpad, byte reads) and finally a report with the raw
// temperature in sixteenths of a degree or an error status. Requests that do not fit
// the current phase are dropped without a result. One request is taken every cycle unless
// in_stall holds it; a request is held in the input register until the sequencer takes
// it, and its result is registered in the output register or its skid stage.
// in_stall rises only while both the result register and its skid stage hold results
// that the consumer has not taken. cfg_we writes the wait time and is meant to be used
// only while no read is in flight.
module onewire_temp_sensor_read_sequencer_top #(
  parameter int SCRATCH_BYTES = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic               in_presence,
  input  logic [7:0]         in_read_data,
  input  logic [7:0]         in_pin,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_cmd_kind,
  output logic [7:0]         out_cmd_pin,
  output logic [7:0]         out_write_data,
  output logic [15:0]        out_delay_ms,
  output logic [1:0]         out_status_code,
  output logic signed [15:0] out_temp_sixteenths
);

  logic           a_vld_r, a_vld_nxt;
  logic [1:0]     a_op_r;
  logic           a_pres_r;
  logic [7:0]     a_data_r;
  logic [7:0]     a_pin_r;
  logic           a_go;
  logic           in_acc;
  logic           buf_full;
  logic           res_vld;
  owts_pkg::res_t res;
  owts_pkg::res_t out_res;

  assign a_go      = a_vld_r && !buf_full;
  assign in_stall  = a_vld_r && buf_full;
  assign in_acc    = in_valid && !in_stall;
  assign a_vld_nxt = in_acc || (a_vld_r && !a_go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_op_r   <= in_op;
      a_pres_r <= in_presence;
      a_data_r <= in_read_data;
      a_pin_r  <= in_pin;
    end
  end

  owts_seq #(
    .SCRATCH_BYTES (SCRATCH_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .go        (a_go),
    .op        (owts_pkg::op_t'(a_op_r)),
    .presence  (a_pres_r),
    .read_data (a_data_r),
    .pin       (a_pin_r),
    .res_vld   (res_vld),
    .res       (res)
  );

  owts_out_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .full      (buf_full),
    .out_vld   (out_valid),
    .out_data  (out_res),
    .out_stall (out_stall)
  );

  assign out_cmd_kind        = out_res.kind;
  assign out_cmd_pin         = out_res.pin;
  assign out_write_data      = out_res.wdata;
  assign out_delay_ms        = out_res.delay_ms;
  assign out_status_code     = out_res.status;
  assign out_temp_sixteenths = out_res.temp;

endmodule
